// File: src/sobm_pkg.sv
// Shared types, constants and helpers for the Sobel edge magnitude block.
package sobm_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;

	localparam int W_W       = 12;   // frame_width register / effective width
	localparam int H_W       = 13;   // frame_height register / effective height
	localparam int COL_W     = 11;
	localparam int ROW_W     = 12;
	localparam int ADDR_W    = 13;   // line store address, wraps naturally
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int CNT_W     = 24;   // pixel index within a frame
	localparam int PEND_W    = 13;
	localparam int GRAD_W    = 11;
	localparam int SQ_W      = 22;
	localparam int ROOT_W    = 11;
	localparam int REM_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;
	localparam int NUM_CH    = 3;
	localparam int NUM_TAPS  = 9;
	localparam int TAP_W     = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [W_W-1:0]   WIDTH_RESET  = 12'd640;
	localparam logic [H_W-1:0]   HEIGHT_RESET = 13'd480;
	localparam logic [CNT_W-1:0] LAST_RESET   = CNT_W'(640 * 480 - 1);
	localparam logic [7:0]       MAG_LIMIT    = 8'd255;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} px_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} px_out_t;

	// write port of the line store
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [23:0]       data;
	} mem_wr_t;

	// one output to be computed
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [W_W-1:0]    width;
		logic [H_W-1:0]    height;
		logic              frame_end;
	} job_t;

	function automatic logic [W_W-1:0] eff_width(input logic [W_W-1:0] v);
		logic [W_W-1:0] r;
		r = v;
		if (v == '0)
			r = W_W'(1);
		else if (v > W_W'(MAX_WIDTH))
			r = W_W'(MAX_WIDTH);
		return r;
	endfunction

	function automatic logic [H_W-1:0] eff_height(input logic [H_W-1:0] v);
		logic [H_W-1:0] r;
		r = v;
		if (v == '0)
			r = H_W'(1);
		else if (v > H_W'(MAX_HEIGHT))
			r = H_W'(MAX_HEIGHT);
		return r;
	endfunction

endpackage

// File: src/sobm_front.sv
// Front end: accepts transactions, stores pixels and schedules outputs.
module sobm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sobm_pkg::px_in_t              in_data,
	input  logic                          cfg_we,
	input  logic [sobm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sobm_pkg::CFG_DAT_W-1:0] cfg_data,
	output sobm_pkg::mem_wr_t             mem_wr,
	output logic                          job_valid,
	input  logic                          job_ready,
	output sobm_pkg::job_t                job
);
	import sobm_pkg::*;

	logic [W_W-1:0]    width_q;
	logic [H_W-1:0]    height_q;
	logic [CNT_W-1:0]  last_q;
	logic [CNT_W-1:0]  here_q;
	logic [PEND_W-1:0] pend_q;
	logic [ADDR_W-1:0] wr_q;
	logic [COL_W-1:0]  ocol_q;
	logic [ROW_W-1:0]  orow_q;

	logic [W_W-1:0]    w_eff, nw;
	logic [H_W-1:0]    h_eff, nh;
	logic [W_W+H_W-1:0] prod;
	logic              accept, pix, emit, cfg_hit;
	logic [PEND_W-1:0] pend_nx;
	logic [CNT_W-1:0]  remain, need, wp1;

	// effective sizes and the new frame length on a register write
	always_comb begin
		w_eff   = eff_width(width_q);
		h_eff   = eff_height(height_q);
		cfg_hit = cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);
		nw      = (cfg_index == CFG_FRAME_WIDTH) ? eff_width(cfg_data[W_W-1:0]) : w_eff;
		nh      = (cfg_index == CFG_FRAME_HEIGHT) ? eff_height(cfg_data) : h_eff;
		prod    = (W_W+H_W)'(nw) * (W_W+H_W)'(nh);
	end

	// readiness of the head output
	always_comb begin
		accept  = in_valid && in_ready;
		pix     = accept && (in_data.op == OP_PIXEL);
		pend_nx = pend_q + PEND_W'(pix);
		remain  = last_q - here_q;
		wp1     = CNT_W'(w_eff) + CNT_W'(1);
		need    = (remain < wp1) ? remain : wp1;
		emit    = accept && (pend_nx != '0) && (CNT_W'(pend_nx) > need);
	end

	assign in_ready  = job_ready;
	assign job_valid = emit;

	always_comb begin
		job.base      = wr_q + ADDR_W'(pix) - pend_nx;
		job.row       = orow_q;
		job.col       = ocol_q;
		job.width     = w_eff;
		job.height    = h_eff;
		job.frame_end = (here_q == last_q);
		mem_wr.en     = pix;
		mem_wr.addr   = wr_q;
		mem_wr.data   = {in_data.red_in, in_data.green_in, in_data.blue_in};
	end

	// configuration, positions and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			last_q   <= LAST_RESET;
			here_q   <= '0;
			pend_q   <= '0;
			wr_q     <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == CFG_FRAME_WIDTH)
				width_q <= cfg_data[W_W-1:0];
			else
				height_q <= cfg_data;
			last_q <= CNT_W'(prod - (W_W+H_W)'(1));
			here_q <= '0;
			pend_q <= '0;
			wr_q   <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (accept) begin
			wr_q   <= wr_q + ADDR_W'(pix);
			pend_q <= pend_nx - PEND_W'(emit);
			if (emit) begin
				here_q <= (here_q == last_q) ? '0 : here_q + CNT_W'(1);
				if (W_W'(ocol_q) == w_eff - W_W'(1)) begin
					ocol_q <= '0;
					orow_q <= (H_W'(orow_q) == h_eff - H_W'(1)) ? '0 : orow_q + ROW_W'(1);
				end else begin
					ocol_q <= ocol_q + COL_W'(1);
				end
			end
		end
	end

endmodule

// File: src/sobm_jobq.sv
// Two-entry queue of scheduled outputs between front and back end.
module sobm_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sobm_pkg::job_t push_data,
	output logic           push_ready,
	output logic           pop_valid,
	input  logic           pop,
	output sobm_pkg::job_t pop_data
);
	import sobm_pkg::*;

	job_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && push_ready)
			ent_q[wp_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && push_ready)
				wp_q <= ~wp_q;
			if (pop && pop_valid)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && push_ready) - 2'(pop && pop_valid);
		end
	end

endmodule

// File: src/sobm_back.sv
// Back end: line store, 3x3 window fetch, Sobel gradients and rounded root.
module sobm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sobm_pkg::mem_wr_t mem_wr,
	input  logic              job_valid,
	output logic              job_ready,
	input  sobm_pkg::job_t    job,
	output logic              out_valid,
	input  logic              out_ready,
	output sobm_pkg::px_out_t out_data
);
	import sobm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_FILL = 3'd2;
	localparam logic [2:0] ST_GRAD = 3'd3;
	localparam logic [2:0] ST_SQX  = 3'd4;
	localparam logic [2:0] ST_SQY  = 3'd5;
	localparam logic [2:0] ST_ROOT = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [23:0]       mem_q [MEM_DEPTH];
	logic [23:0]       rd_q;
	logic [2:0]        state_q;
	job_t              job_q;
	logic [1:0]        rr_q, cc_q;
	logic              issue_q, keep_q;
	logic [TAP_W-1:0]  tap_q;
	logic [23:0]       win_q [NUM_TAPS];
	logic signed [GRAD_W-1:0] gx_q [NUM_CH];
	logic signed [GRAD_W-1:0] gy_q [NUM_CH];
	logic [SQ_W-1:0]   rad_q  [NUM_CH];
	logic [REM_W-1:0]  rem_q  [NUM_CH];
	logic [ROOT_W-1:0] root_q [NUM_CH];
	logic [3:0]        step_q;
	logic              out_valid_q;
	px_out_t           out_q;

	logic [ADDR_W-1:0] rd_addr, w13, row_off;
	logic              keep, load_out;
	logic signed [GRAD_W-1:0] gx [NUM_CH];
	logic signed [GRAD_W-1:0] gy [NUM_CH];
	logic [REM_W-1:0]  rem_n [NUM_CH];
	logic [REM_W-1:0]  trial [NUM_CH];
	logic              ge [NUM_CH];
	logic [7:0]        mag [NUM_CH];
	logic [ROOT_W:0]   rnd [NUM_CH];

	// tap address and frame mask
	always_comb begin
		w13 = ADDR_W'(job_q.width);
		case (rr_q)
			2'd0:    row_off = -w13;
			2'd2:    row_off = w13;
			default: row_off = '0;
		endcase
		rd_addr = job_q.base + row_off + ADDR_W'(cc_q) - ADDR_W'(1);
		keep = (rr_q != 2'd0 || job_q.row != '0)
			&& (rr_q != 2'd2 || H_W'(job_q.row) != job_q.height - H_W'(1))
			&& (cc_q != 2'd0 || job_q.col != '0)
			&& (cc_q != 2'd2 || W_W'(job_q.col) != job_q.width - W_W'(1));
	end

	// line store
	always_ff @(posedge clk) begin
		if (mem_wr.en)
			mem_q[mem_wr.addr] <= mem_wr.data;
		rd_q <= mem_q[rd_addr];
	end

	// gradients, root step and rounding per channel
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			gx[ch] = GRAD_W'($signed({3'b0, win_q[2][23-8*ch -: 8]}))
				+ GRAD_W'($signed({2'b0, win_q[5][23-8*ch -: 8], 1'b0}))
				+ GRAD_W'($signed({3'b0, win_q[8][23-8*ch -: 8]}))
				- GRAD_W'($signed({3'b0, win_q[0][23-8*ch -: 8]}))
				- GRAD_W'($signed({2'b0, win_q[3][23-8*ch -: 8], 1'b0}))
				- GRAD_W'($signed({3'b0, win_q[6][23-8*ch -: 8]}));
			gy[ch] = GRAD_W'($signed({3'b0, win_q[6][23-8*ch -: 8]}))
				+ GRAD_W'($signed({2'b0, win_q[7][23-8*ch -: 8], 1'b0}))
				+ GRAD_W'($signed({3'b0, win_q[8][23-8*ch -: 8]}))
				- GRAD_W'($signed({3'b0, win_q[0][23-8*ch -: 8]}))
				- GRAD_W'($signed({2'b0, win_q[1][23-8*ch -: 8], 1'b0}))
				- GRAD_W'($signed({3'b0, win_q[2][23-8*ch -: 8]}));
			rem_n[ch] = {rem_q[ch][REM_W-3:0], rad_q[ch][SQ_W-1 -: 2]};
			trial[ch] = {root_q[ch], 2'b01};
			ge[ch]    = (rem_n[ch] >= trial[ch]);
			rnd[ch]   = {1'b0, root_q[ch]} + (ROOT_W+1)'(rem_q[ch] > REM_W'(root_q[ch]));
			mag[ch]   = (rnd[ch] > (ROOT_W+1)'(MAG_LIMIT)) ? MAG_LIMIT : rnd[ch][7:0];
		end
	end

	assign job_ready = (state_q == ST_IDLE);
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// window capture from registered read data
	always_ff @(posedge clk) begin
		if (issue_q)
			win_q[tap_q] <= keep_q ? rd_q : 24'd0;
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid)
			job_q <= job;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			case (state_q)
				ST_GRAD: begin
					gx_q[ch] <= gx[ch];
					gy_q[ch] <= gy[ch];
				end
				ST_SQX: begin
					rad_q[ch] <= SQ_W'(gx_q[ch] * gx_q[ch]);
				end
				ST_SQY: begin
					rad_q[ch]  <= rad_q[ch] + SQ_W'(gy_q[ch] * gy_q[ch]);
					rem_q[ch]  <= '0;
					root_q[ch] <= '0;
				end
				ST_ROOT: begin
					rad_q[ch]  <= {rad_q[ch][SQ_W-3:0], 2'b00};
					rem_q[ch]  <= ge[ch] ? rem_n[ch] - trial[ch] : rem_n[ch];
					root_q[ch] <= {root_q[ch][ROOT_W-2:0], ge[ch]};
				end
				default: begin
				end
			endcase
		end
		if (load_out) begin
			out_q.red_out   <= mag[0];
			out_q.green_out <= mag[1];
			out_q.blue_out  <= mag[2];
			out_q.frame_end <= job_q.frame_end;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rr_q        <= '0;
			cc_q        <= '0;
			issue_q     <= 1'b0;
			keep_q      <= 1'b0;
			tap_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			issue_q <= (state_q == ST_READ);
			keep_q  <= keep;
			tap_q   <= TAP_W'(rr_q) * TAP_W'(3) + TAP_W'(cc_q);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					rr_q <= '0;
					cc_q <= '0;
					if (job_valid)
						state_q <= ST_READ;
				end
				ST_READ: begin
					if (cc_q == 2'd2) begin
						cc_q <= '0;
						rr_q <= rr_q + 2'd1;
						if (rr_q == 2'd2)
							state_q <= ST_FILL;
					end else begin
						cc_q <= cc_q + 2'd1;
					end
				end
				ST_FILL: state_q <= ST_GRAD;
				ST_GRAD: state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY: begin
					step_q  <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'(ROOT_W - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/sobel_edge_magnitude_rgb.sv
// Top level of the streaming RGB Sobel edge magnitude block.
// Pixels enter in raster order; outputs leave in raster order, one line plus one pixel
// behind, and flush transactions drain the tail of a frame. Input transactions are taken
// at one per cycle while the two-entry output queue has room; each output then passes
// through nine line-store reads, a fill step, gradient, two squaring steps, eleven
// square-root iterations and a result load; a new output starts once the last is loaded.
// A register write restarts the stream. No clearing pass is needed after reset.
module sobel_edge_magnitude_rgb (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  sobm_pkg::px_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output sobm_pkg::px_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [sobm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sobm_pkg::CFG_DAT_W-1:0] cfg_data
);
	import sobm_pkg::*;

	mem_wr_t mem_wr;
	job_t    fr_job, bk_job;
	logic    fr_valid, q_ready, bk_valid, bk_pop;

	sobm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mem_wr    (mem_wr),
		.job_valid (fr_valid),
		.job_ready (q_ready),
		.job       (fr_job)
	);

	sobm_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fr_valid),
		.push_data  (fr_job),
		.push_ready (q_ready),
		.pop_valid  (bk_valid),
		.pop        (bk_pop),
		.pop_data   (bk_job)
	);

	sobm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_wr    (mem_wr),
		.job_valid (bk_valid),
		.job_ready (bk_pop),
		.job       (bk_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the streaming RGB Sobel edge magnitude block.
module testbench;
	import sobm_pkg::*;

	localparam int RING      = 2 * MAX_WIDTH + 4;
	localparam int QUIET     = 150;  // idle cycles before a register write
	localparam int TAIL      = 300;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum logic [1:0] {K_PIXEL, K_CFG, K_HOLD} step_kind_e;

	typedef struct {
		step_kind_e               kind;
		px_in_t                   item;
		logic [CFG_IDX_W-1:0]     idx;
		logic [CFG_DAT_W-1:0]     val;
	} step_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	px_in_t in_data;
	px_out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	sobel_edge_magnitude_rgb u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	step_t   plan[$];
	px_out_t grad_q[$];
	int      fails = 0;
	int      gap = 0, ostall = 0, quiet = 0, n_items = 0;
	bit      calm = 0;
	logic    nx_we;

	// predictor state
	logic [11:0]    reg_w;
	logic [12:0]    reg_h;
	logic [23:0]    line_ring[RING];
	int unsigned    p_wr, p_pend, p_icol, p_irow, p_ocol, p_orow;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int unsigned width_used();
		if (reg_w == 0) return 1;
		if (reg_w > MAX_WIDTH) return MAX_WIDTH;
		return reg_w;
	endfunction

	function automatic int unsigned height_used();
		if (reg_h == 0) return 1;
		if (reg_h > MAX_HEIGHT) return MAX_HEIGHT;
		return reg_h;
	endfunction

	function automatic void stream_restart();
		p_wr = 0; p_pend = 0;
		p_icol = 0; p_irow = 0; p_ocol = 0; p_orow = 0;
	endfunction

	function automatic void cfg_apply(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		if (idx == CFG_FRAME_WIDTH) begin
			reg_w = val[11:0];
			stream_restart();
		end else if (idx == CFG_FRAME_HEIGHT) begin
			reg_h = val;
			stream_restart();
		end
	endfunction

	// square root rounded to nearest
	function automatic int unsigned root_near(int unsigned s);
		int unsigned r, t, b;
		r = 0;
		for (b = 1 << 11; b != 0; b = b >> 1) begin
			t = r | b;
			if (t * t <= s) r = t;
		end
		if (s - r * r > r) r++;
		return r;
	endfunction

	// gradient magnitude of the pixel at the output position
	function automatic px_out_t grad_at(int unsigned w, int unsigned h);
		px_out_t o;
		longint  base, r, c, idx;
		logic [23:0] v;
		int gx[3], gy[3], p, kx, ky, mag;
		base = longint'(p_wr) + RING - p_pend;
		for (int ch = 0; ch < 3; ch++) begin
			gx[ch] = 0; gy[ch] = 0;
		end
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++) begin
				r = longint'(p_orow) + dr;
				c = longint'(p_ocol) + dc;
				v = '0;
				if (r >= 0 && r < h && c >= 0 && c < w) begin
					idx = (base + dr * longint'(w) + dc) % RING;
					if (idx < 0) idx += RING;
					v = line_ring[idx];
				end
				kx = dc * ((dr == 0) ? 2 : 1);
				ky = dr * ((dc == 0) ? 2 : 1);
				for (int ch = 0; ch < 3; ch++) begin
					p = v[23 - 8 * ch -: 8];
					gx[ch] += p * kx;
					gy[ch] += p * ky;
				end
			end
		for (int ch = 0; ch < 3; ch++) begin
			mag = root_near(gx[ch] * gx[ch] + gy[ch] * gy[ch]);
			if (mag > MAG_LIMIT) mag = MAG_LIMIT;
			case (ch)
				0: o.red_out = mag[7:0];
				1: o.green_out = mag[7:0];
				default: o.blue_out = mag[7:0];
			endcase
		end
		o.frame_end = (p_orow == h - 1 && p_ocol == w - 1);
		return o;
	endfunction

	// per accepted transaction: store the pixel of a pixel op, queue at most one ready output
	function automatic void sobel_predict(px_in_t it);
		int unsigned w, h;
		longint last, here, need;
		w = width_used();
		h = height_used();
		if (it.op == OP_PIXEL) begin
			line_ring[p_wr] = {it.red_in, it.green_in, it.blue_in};
			p_wr = (p_wr + 1 >= RING) ? 0 : p_wr + 1;
			p_pend++;
			p_icol++;
			if (p_icol >= w) begin
				p_icol = 0;
				p_irow = (p_irow + 1 >= h) ? 0 : p_irow + 1;
			end
		end
		if (p_pend == 0) return;
		last = longint'(h) * w - 1;
		here = longint'(p_orow) * w + p_ocol;
		need = longint'(w) + 1;
		if (last - here < need) need = last - here;
		if (p_pend < need + 1) return;
		grad_q.push_back(grad_at(w, h));
		p_pend--;
		p_ocol++;
		if (p_ocol >= w) begin
			p_ocol = 0;
			p_orow = (p_orow + 1 >= h) ? 0 : p_orow + 1;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] chan_val();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		step_t s;
		s.kind = K_CFG; s.idx = idx; s.val = val; s.item = '0;
		plan.push_back(s);
	endfunction

	function automatic void add_hold();
		step_t s;
		s.kind = K_HOLD; s.idx = '0; s.val = '0; s.item = '0;
		plan.push_back(s);
	endfunction

	function automatic void add_px(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		step_t s;
		s.kind = K_PIXEL; s.idx = '0; s.val = '0;
		s.item.op = op; s.item.red_in = r; s.item.green_in = g; s.item.blue_in = b;
		plan.push_back(s);
		n_items++;
	endfunction

	function automatic void add_rand_px(int n, int flush_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < flush_pct)
				add_px(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
			add_px(OP_PIXEL, chan_val(), chan_val(), chan_val());
		end
	endfunction

	function automatic void add_flushes(int n);
		for (int i = 0; i < n; i++)
			add_px(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
	endfunction

	// stimulus plan
	initial begin
		int w, h;
		reg_w = WIDTH_RESET;
		reg_h = HEIGHT_RESET;
		stream_restart();

		// directed: 3x3 frame of extremes with a flush in mid-frame
		add_cfg(CFG_FRAME_WIDTH, 13'd3);
		add_cfg(CFG_FRAME_HEIGHT, 13'd3);
		add_px(OP_PIXEL, 8'd255, 8'd0, 8'd255);
		add_px(OP_PIXEL, 8'd0, 8'd255, 8'd0);
		add_px(OP_FLUSH, 8'd255, 8'd255, 8'd255);
		add_px(OP_PIXEL, 8'd255, 8'd255, 8'd0);
		add_px(OP_PIXEL, 8'd0, 8'd0, 8'd255);
		add_px(OP_PIXEL, 8'd255, 8'd0, 8'd0);
		add_px(OP_PIXEL, 8'd255, 8'd255, 8'd255);
		add_px(OP_PIXEL, 8'd0, 8'd0, 8'd0);
		add_px(OP_PIXEL, 8'd255, 8'd255, 8'd255);
		add_flushes(5);
		// back-to-back 2x2 frames, tail of the first drained by the second
		add_cfg(CFG_FRAME_WIDTH, 13'd2);
		add_cfg(CFG_FRAME_HEIGHT, 13'd2);
		add_rand_px(8, 0);
		add_flushes(4);
		// zero sizes act as one; spare register index is ignored
		add_cfg(CFG_FRAME_WIDTH, 13'd0);
		add_cfg(CFG_FRAME_HEIGHT, 13'd0);
		add_cfg(CFG_SPARE, 13'h1fff);
		add_rand_px(3, 0);
		add_flushes(2);

		// oversize registers clamp to the maxima; partial frames only
		add_cfg(CFG_FRAME_WIDTH, 13'd1);
		add_cfg(CFG_FRAME_HEIGHT, 13'h1fff);
		add_rand_px(12, 10);
		add_cfg(CFG_FRAME_HEIGHT, 13'd1);
		add_cfg(CFG_FRAME_WIDTH, 13'hfff);
		add_rand_px(24, 0);
		add_flushes(4);
		add_cfg(CFG_FRAME_WIDTH, 13'd2048);
		add_cfg(CFG_FRAME_HEIGHT, 13'd4096);
		add_rand_px(30, 0);

		// random frames of small sizes
		while (n_items < 700) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
			h = $urandom_range(1, 6);
			add_cfg(CFG_FRAME_WIDTH, 13'(w));
			add_cfg(CFG_FRAME_HEIGHT, 13'(h));
			for (int f = $urandom_range(1, 3); f > 0; f--) begin
				add_rand_px(w * h, 8);
				if ($urandom_range(0, 5) == 0) add_hold();
			end
			if ($urandom_range(0, 3) != 0) add_flushes(w + 3);
		end
	end

	// drive input transactions and register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			cfg_we <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
		end else begin
			nx_we = 1'b0;
			if (in_valid && in_ready) sobel_predict(in_data);
			if ($urandom_range(0, 63) == 0) calm = ~calm;
			if (in_valid && !in_ready) begin
				// hold the transaction
			end else if (gap > 0) begin
				gap--;
				in_valid <= 1'b0;
			end else if (plan.size() == 0) begin
				in_valid <= 1'b0;
			end else if (plan[0].kind == K_PIXEL) begin
				in_valid <= 1'b1;
				in_data <= plan[0].item;
				void'(plan.pop_front());
				gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
				if (grad_q.size() == 0 && quiet >= QUIET) begin
					if (plan[0].kind == K_CFG) begin
						nx_we = 1'b1;
						cfg_index <= plan[0].idx;
						cfg_data <= plan[0].val;
						cfg_apply(plan[0].idx, plan[0].val);
					end
					void'(plan.pop_front());
				end
			end
			cfg_we <= nx_we;
		end
	end

	// idle time since the last expected result, input transaction or register write
	always @(posedge clk) begin
		if (grad_q.size() != 0 || in_valid || cfg_we)
			quiet = 0;
		else
			quiet++;
	end

	// check output transactions, stall the receiver at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (grad_q.size() == 0) begin
					$display("%0t: unexpected output %h", $time, out_data);
					fails++;
				end else begin
					if (out_data.red_out !== grad_q[0].red_out) begin
						$display("%0t: red_out exp %0d got %0d", $time,
							grad_q[0].red_out, out_data.red_out);
						fails++;
					end
					if (out_data.green_out !== grad_q[0].green_out) begin
						$display("%0t: green_out exp %0d got %0d", $time,
							grad_q[0].green_out, out_data.green_out);
						fails++;
					end
					if (out_data.blue_out !== grad_q[0].blue_out) begin
						$display("%0t: blue_out exp %0d got %0d", $time,
							grad_q[0].blue_out, out_data.blue_out);
						fails++;
					end
					if (out_data.frame_end !== grad_q[0].frame_end) begin
						$display("%0t: frame_end exp %0b got %0b", $time,
							grad_q[0].frame_end, out_data.frame_end);
						fails++;
					end
					void'(grad_q.pop_front());
				end
			end
			if (ostall > 0) begin
				ostall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				ostall = pick_gap();
			end
		end
	end

	// end of run
	initial begin
		@(posedge arst_n);
		while (plan.size() != 0 || in_valid || grad_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (grad_q.size() == 0 && fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (grad_q.size() != 0)
				$display("%0t: %0d expected outputs never came", $time, grad_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(64'd20 * 64'd3_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
